// ===== design/qbtp_pkg.sv =====
// ----------------------------------------------------------------------------
// qbtp_pkg
// Shared types, constants and the color palette of the quadrant and bar
// test pattern generator.
// ----------------------------------------------------------------------------
package qbtp_pkg;

	// frame geometry limits and defaults
	localparam int          MAX_DIMENSION = 4096;
	localparam int          DIM_W         = 13;
	localparam int          POS_W         = 12;
	localparam int          SPAN_W        = 7;
	localparam logic [12:0] DIM_TOP       = 13'(MAX_DIMENSION) & ~13'd1;
	localparam logic [12:0] DEFAULT_WIDTH  = 13'd1280;
	localparam logic [12:0] DEFAULT_HEIGHT = 13'd720;
	localparam logic [12:0] MIN_WIDTH      = 13'd16;
	localparam logic [12:0] MIN_HEIGHT     = 13'd2;

	// bar geometry
	localparam logic [6:0]  BAR_MIN      = 7'd8;
	localparam logic [12:0] BAR_STEP     = 13'd7;
	// reciprocal of 5 in 10 fractional bits, exact for dividends below 1024
	localparam logic [17:0] RECIP_FIVE   = 18'd205;
	localparam logic [6:0]  DEFAULT_SPAN = 7'(DEFAULT_WIDTH / 40);

	localparam logic [7:0]  WHITE = 8'd255;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic        end_of_line;
		logic        end_of_frame;
		logic [31:0] frame_number;
	} pixel_t;

	// fixed four-color palette
	function automatic rgb_t palette(input logic [1:0] idx);
		rgb_t c;
		case (idx)
			2'd0:    c = '{red: 8'd220, green: 8'd40,  blue: 8'd40};
			2'd1:    c = '{red: 8'd40,  green: 8'd200, blue: 8'd60};
			2'd2:    c = '{red: 8'd50,  green: 8'd70,  blue: 8'd230};
			default: c = '{red: 8'd230, green: 8'd200, blue: 8'd40};
		endcase
		return c;
	endfunction

endpackage

// ===== design/qbtp_if.sv =====
// ----------------------------------------------------------------------------
// qbtp_if
// Valid/ready channels of the test pattern generator: the tick channel that
// requests pixels and the pixel channel that returns them.
// ----------------------------------------------------------------------------
interface qbtp_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface qbtp_pixel_if import qbtp_pkg::*;;
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/quadrant_bar_test_pattern.sv =====
// ----------------------------------------------------------------------------
// quadrant_bar_test_pattern
// Raster test pattern source: four palette quadrants rotating per frame with
// a white vertical bar that steps across the frame.
// ----------------------------------------------------------------------------
// Every tick transaction yields one pixel transaction, one per clock
// sustained while the pixel channel is ready: the raster counters advance
// on every accepted tick and the pixel is registered into a two-entry output
// buffer, so a tick is still taken while one finished pixel waits downstream.
// A write to either geometry register, or a tick with restart set,
// returns the raster, frame number and bar position to zero. Width and height
// are forced even, zero selects 1280x720, widths clamp to 16..4096 and
// heights to 2..4096; the bar is max(8, width/40) pixels wide.
module quadrant_bar_test_pattern import qbtp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_wdata,
	qbtp_tick_if.sink         tick,
	qbtp_pixel_if.source      pixel
);

	// clamp a raw dimension to an even legal value
	function automatic logic [12:0] fit_dim(input logic [12:0] raw,
		input logic [12:0] dflt, input logic [12:0] low);
		logic [12:0] v;
		v = {raw[12:1], 1'b0};
		if (v == 13'd0) v = dflt;
		if (v > DIM_TOP) v = DIM_TOP;
		if (v < low) v = low;
		return v;
	endfunction

	// max(8, w / 40) as (w / 8) / 5 by reciprocal multiply
	function automatic logic [6:0] span_of(input logic [12:0] w);
		logic [17:0] prod;
		logic [7:0]  q;
		prod = 18'(w[12:3]) * RECIP_FIVE;
		q = prod[17:10];
		return (q < 8'(BAR_MIN)) ? BAR_MIN : q[6:0];
	endfunction

	logic [DIM_W-1:0]  eff_w_q, eff_h_q, wrap_q;
	logic [SPAN_W-1:0] span_q;
	logic [POS_W-1:0]  col_q, row_q, bar_q;
	logic [31:0]       frame_q;

	pixel_t out_q, skid_q;
	logic   out_v_q, skid_v_q;

	// geometry derived from a write
	logic [DIM_W-1:0]  new_w, new_wrap;
	logic [SPAN_W-1:0] new_span;

	assign new_w    = fit_dim(cfg_wdata, DEFAULT_WIDTH, MIN_WIDTH);
	assign new_span = span_of(new_w);
	assign new_wrap = new_w - 13'(new_span);

	// geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= DEFAULT_WIDTH;
			eff_h_q <= DEFAULT_HEIGHT;
			span_q  <= DEFAULT_SPAN;
			wrap_q  <= DEFAULT_WIDTH - 13'(DEFAULT_SPAN);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					eff_w_q <= new_w;
					span_q  <= new_span;
					wrap_q  <= new_wrap;
				end
				REG_FRAME_HEIGHT: begin
					eff_h_q <= fit_dim(cfg_wdata, DEFAULT_HEIGHT, MIN_HEIGHT);
				end
			endcase
		end
	end

	// handshake
	logic accept, take;

	assign tick.ready = !skid_v_q;
	assign accept     = tick.valid && tick.ready;
	assign take       = out_v_q && pixel.ready;

	// current position, with restart applied
	logic [POS_W-1:0] col, row, bar;
	logic [31:0]      frame;

	assign col   = tick.restart ? '0 : col_q;
	assign row   = tick.restart ? '0 : row_q;
	assign bar   = tick.restart ? '0 : bar_q;
	assign frame = tick.restart ? '0 : frame_q;

	// pixel color and raster flags
	logic [1:0]       quad;
	logic             in_bar, eol, eof;
	rgb_t             base;
	pixel_t           pix;
	logic [DIM_W-1:0] bar_sum;
	logic [POS_W-1:0] bar_next;

	assign quad   = {row >= eff_h_q[12:1], col >= eff_w_q[12:1]};
	assign base   = palette(frame[1:0] + quad);
	assign in_bar = (col >= bar) && ({1'b0, col} < ({1'b0, bar} + 13'(span_q)));
	assign eol    = ({1'b0, col} + 13'd1) >= eff_w_q;
	assign eof    = eol && (({1'b0, row} + 13'd1) >= eff_h_q);

	always_comb begin
		pix.blue         = in_bar ? WHITE : base.blue;
		pix.green        = in_bar ? WHITE : base.green;
		pix.red          = in_bar ? WHITE : base.red;
		pix.pixel_x      = col;
		pix.pixel_y      = row;
		pix.end_of_line  = eol;
		pix.end_of_frame = eof;
		pix.frame_number = frame;
	end

	// bar advance with wrap
	assign bar_sum  = {1'b0, bar} + BAR_STEP;
	assign bar_next = (bar_sum >= wrap_q) ? 12'(bar_sum - wrap_q) : bar_sum[11:0];

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			bar_q   <= '0;
			frame_q <= '0;
		end else if (cfg_we) begin
			col_q   <= '0;
			row_q   <= '0;
			bar_q   <= '0;
			frame_q <= '0;
		end else if (accept) begin
			if (!eol) begin
				col_q   <= col + 12'd1;
				row_q   <= row;
				bar_q   <= bar;
				frame_q <= frame;
			end else if (!eof) begin
				col_q   <= '0;
				row_q   <= row + 12'd1;
				bar_q   <= bar;
				frame_q <= frame;
			end else begin
				col_q   <= '0;
				row_q   <= '0;
				bar_q   <= bar_next;
				frame_q <= frame + 32'd1;
			end
		end
	end

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= pix;
			end
		end else if (accept) begin
			skid_q <= pix;
		end
	end

	assign pixel.valid = out_v_q;
	assign pixel.data  = out_q;

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds a pixel while the output register is empty");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (col_q == '0) && (row_q == '0) && (frame_q == '0) && (bar_q == '0))
		else $error("counters not cleared by a configuration write");

	a_bar_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, bar_q} < wrap_q)
		else $error("bar start beyond its wrap span");

	a_raster_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < eff_w_q) && ({1'b0, row_q} < eff_h_q))
		else $error("raster position outside the frame");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrant and bar test pattern generator. A
// directed stimulus table covers the reset geometry, restarts and the
// zero, odd, oversize and narrow register values. Random tick traffic then
// runs over a series of frame geometries, mostly small enough for many frame
// and bar wraps. Every pixel transaction is compared field by field against
// an in-bench raster model, under changing valid and ready idle patterns.
// ----------------------------------------------------------------------------
module tb_top import qbtp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DFLT_W      = 1280;
	localparam int unsigned DFLT_H      = 720;
	localparam int unsigned DIM_MAX     = 4096;
	localparam int unsigned NARROW_W    = 16;
	localparam int unsigned SHORT_H     = 2;
	localparam int unsigned SPAN_DIV    = 40;
	localparam int unsigned SPAN_MIN    = 8;
	localparam int unsigned BAR_ADVANCE = 7;
	localparam int          NUM_PHASES  = 12;
	localparam int          STALL_LIMIT = 2000;
	localparam int          PRINT_LIMIT = 40;

	// palette in red, green, blue order
	localparam rgb_t SWATCH [4] = '{
		'{red: 8'd220, green: 8'd40,  blue: 8'd40},
		'{red: 8'd40,  green: 8'd200, blue: 8'd60},
		'{red: 8'd50,  green: 8'd70,  blue: 8'd230},
		'{red: 8'd230, green: 8'd200, blue: 8'd40}
	};

	typedef struct {
		bit     typed;
		pixel_t px;
	} note_t;

	typedef struct {
		bit          is_write;
		logic        sel;
		logic [12:0] val;
		bit          rst;
		bit          typed;
		pixel_t      want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [12:0] cfg_wdata;

	qbtp_tick_if  tick_ch ();
	qbtp_pixel_if pixel_ch ();

	quadrant_bar_test_pattern uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.pixel     (pixel_ch)
	);

	// raster model state
	logic [12:0] width_reg;
	logic [12:0] height_reg;
	int unsigned eff_w;
	int unsigned eff_h;
	int unsigned col;
	int unsigned row;
	bit [31:0]   frame_cnt;
	int unsigned bar_lo;
	int unsigned bar_wide;

	pixel_t pixels_due [$];
	note_t  typed_notes [$];

	int tx_idle = 30;
	int rx_idle = 83;
	int ticks_sent;
	int pixels_seen;
	int frames_seen;
	int restarts_sent;
	int writes_seen;
	int errors;
	int stall_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// register value to effective dimension
	function automatic int unsigned fit_dim(input int unsigned raw, input int unsigned dflt,
			input int unsigned low);
		int unsigned v;
		v = raw & ~32'd1;
		if (v == 0) v = dflt;
		if (v > DIM_MAX) v = DIM_MAX;
		if (v < low) v = low;
		return v;
	endfunction

	// any register write restarts the raster and resizes the bar
	function automatic void apply_geometry();
		eff_w     = fit_dim(width_reg, DFLT_W, NARROW_W);
		eff_h     = fit_dim(height_reg, DFLT_H, SHORT_H);
		bar_wide  = (eff_w / SPAN_DIV < SPAN_MIN) ? SPAN_MIN : eff_w / SPAN_DIV;
		col       = 0;
		row       = 0;
		frame_cnt = '0;
		bar_lo    = 0;
	endfunction

	// next pixel of the raster, advancing the model
	function automatic pixel_t raster_pixel(input bit rst);
		pixel_t      px;
		rgb_t        c;
		int unsigned quad;
		bit          eol;
		bit          eof;
		if (rst) begin
			col       = 0;
			row       = 0;
			frame_cnt = '0;
			bar_lo    = 0;
		end
		quad = (col >= eff_w / 2 ? 1 : 0) + (row >= eff_h / 2 ? 2 : 0);
		c = SWATCH[(int'(frame_cnt[1:0]) + quad) % 4];
		if (col >= bar_lo && col < bar_lo + bar_wide)
			c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
		eol = (col + 1 >= eff_w);
		eof = eol && (row + 1 >= eff_h);
		px.blue         = c.blue;
		px.green        = c.green;
		px.red          = c.red;
		px.pixel_x      = col[11:0];
		px.pixel_y      = row[11:0];
		px.end_of_line  = eol;
		px.end_of_frame = eof;
		px.frame_number = frame_cnt;
		// raster and bar advance
		if (!eol) begin
			col++;
		end else begin
			col = 0;
			if (!eof) begin
				row++;
			end else begin
				row = 0;
				frame_cnt++;
				bar_lo += BAR_ADVANCE;
				if (bar_lo >= eff_w - bar_wide) bar_lo -= eff_w - bar_wide;
			end
		end
		return px;
	endfunction

	// white pixel of frame zero, not at a line end
	function automatic pixel_t white_px(input int unsigned x, input int unsigned y);
		pixel_t px;
		px.blue         = 8'd255;
		px.green        = 8'd255;
		px.red          = 8'd255;
		px.pixel_x      = x[11:0];
		px.pixel_y      = y[11:0];
		px.end_of_line  = 1'b0;
		px.end_of_frame = 1'b0;
		px.frame_number = '0;
		return px;
	endfunction

	function automatic plan_row_t tick_row(input bit rst, input bit typed, input pixel_t want);
		plan_row_t r;
		r.is_write = 1'b0;
		r.sel      = REG_FRAME_WIDTH;
		r.val      = '0;
		r.rst      = rst;
		r.typed    = typed;
		r.want     = want;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic sel, input logic [12:0] val);
		plan_row_t r;
		r.is_write = 1'b1;
		r.sel      = sel;
		r.val      = val;
		r.rst      = 1'b0;
		r.typed    = 1'b0;
		r.want     = '0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("mismatch %s: got %0d expected %0d at pixel transaction %0d",
				what, got, want, pixels_seen);
	endtask

	// one tick transaction, with random idle cycles ahead of it
	task automatic send_tick(input bit rst, input bit typed, input pixel_t want);
		note_t n;
		while ($urandom_range(0, 99) < tx_idle) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		n.typed = typed;
		n.px    = want;
		typed_notes.push_back(n);
		tick_ch.valid   <= 1'b1;
		tick_ch.restart <= rst;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		ticks_sent++;
		if (rst) restarts_sent++;
	endtask

	// hold ticks until every pixel is back
	task automatic drain();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (pixels_seen != ticks_sent);
	endtask

	// register write once the block is idle
	task automatic write_reg(input logic sel, input logic [12:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// receiver ready pattern
	initial begin
		pixel_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			pixel_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	// model update and pixel check at each edge
	always @(posedge clk) begin
		pixel_t want;
		pixel_t got;
		note_t  n;
		if (!arst_n) begin
			width_reg  = 13'(DFLT_W);
			height_reg = 13'(DFLT_H);
			apply_geometry();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_wdata;
				else
					height_reg = cfg_wdata;
				apply_geometry();
				writes_seen++;
			end
			if (tick_ch.valid && tick_ch.ready) begin
				want = raster_pixel(tick_ch.restart);
				n = typed_notes.pop_front();
				pixels_due.push_back(n.typed ? n.px : want);
			end
			if (pixel_ch.valid && pixel_ch.ready) begin
				got = pixel_ch.data;
				pixels_seen++;
				if (got.end_of_frame) frames_seen++;
				if (pixels_due.size() == 0) begin
					report_mismatch("pixel with none pending, pixel_x", got.pixel_x, 0);
				end else begin
					want = pixels_due.pop_front();
					if (got.blue !== want.blue)
						report_mismatch("blue", got.blue, want.blue);
					if (got.green !== want.green)
						report_mismatch("green", got.green, want.green);
					if (got.red !== want.red)
						report_mismatch("red", got.red, want.red);
					if (got.pixel_x !== want.pixel_x)
						report_mismatch("pixel_x", got.pixel_x, want.pixel_x);
					if (got.pixel_y !== want.pixel_y)
						report_mismatch("pixel_y", got.pixel_y, want.pixel_y);
					if (got.end_of_line !== want.end_of_line)
						report_mismatch("end_of_line", got.end_of_line, want.end_of_line);
					if (got.end_of_frame !== want.end_of_frame)
						report_mismatch("end_of_frame", got.end_of_frame, want.end_of_frame);
					if (got.frame_number !== want.frame_number)
						report_mismatch("frame_number", got.frame_number, want.frame_number);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (tick_ch.valid && tick_ch.ready) || (pixel_ch.valid && pixel_ch.ready)
				|| cfg_we) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		plan_row_t   plan [$];
		int unsigned phase_w [NUM_PHASES];
		int unsigned phase_h [NUM_PHASES];
		int unsigned phase_n [NUM_PHASES];
		arst_n          <= 1'b0;
		tick_ch.valid   <= 1'b0;
		tick_ch.restart <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_FRAME_WIDTH;
		cfg_wdata       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows: reset geometry, restart, register corner values
		plan.push_back(tick_row(1'b0, 1'b1, white_px(0, 0)));
		plan.push_back(tick_row(1'b0, 1'b1, white_px(1, 0)));
		plan.push_back(tick_row(1'b1, 1'b1, white_px(0, 0)));
		plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd8191));
		plan.push_back(tick_row(1'b0, 1'b1, white_px(0, 0)));
		plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd0));
		plan.push_back(tick_row(1'b0, 1'b1, white_px(0, 0)));
		plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd0));
		plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd15));
		plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd8191));
		// odd height of one clears to zero and falls back to the default
		plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd1));
		plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd3));
		plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd17));
		// one full 16-pixel line past the bar into the right quadrant
		for (int i = 0; i < 16; i++)
			plan.push_back(tick_row(1'b0, 1'b0, '0));
		plan.push_back(tick_row(1'b1, 1'b1, white_px(0, 0)));
		for (int i = 0; i < 3; i++)
			plan.push_back(tick_row(1'b0, 1'b0, '0));

		foreach (plan[i]) begin
			if (plan[i].is_write)
				write_reg(plan[i].sel, plan[i].val);
			else
				send_tick(plan[i].rst, plan[i].typed, plan[i].want);
		end

		// random phases, mostly tiny frames so frames and bar wraps are frequent
		phase_w = '{16, 31, $urandom_range(16, 48), 8191, 0, 40,
			$urandom_range(16, 64), 16, $urandom_range(16, 48), 14,
			$urandom_range(16, 64), 64};
		phase_h = '{2, 7, $urandom_range(2, 6), 8191, 2, 1,
			$urandom_range(2, 5), 3, $urandom_range(2, 6), 4,
			$urandom_range(2, 4), 2};
		phase_n = '{90, 80, 80, 30, 30, 60, 80, 80, 90, 80, 90, 90};

		for (int p = 0; p < NUM_PHASES; p++) begin
			// idle mix: slow receiver, then slow sender, then full rate
			case (p / 4)
				0: begin
					tx_idle = 30;
					rx_idle = 83;
				end
				1: begin
					tx_idle = 83;
					rx_idle = 30;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			write_reg(REG_FRAME_WIDTH, 13'(phase_w[p]));
			write_reg(REG_FRAME_HEIGHT, 13'(phase_h[p]));
			for (int i = 0; i < int'(phase_n[p]); i++) begin
				if (i == int'(phase_n[p]) / 2) drain();
				send_tick($urandom_range(0, 24) == 0, 1'b0, '0);
			end
		end

		// wait out the last pixels
		drain();
		repeat (4) @(posedge clk);
		if (pixels_due.size() != 0)
			report_mismatch("pixels still pending", pixels_due.size(), 0);

		$display("covered %0d tick transactions (%0d restarts), %0d frames, %0d register writes",
			ticks_sent, restarts_sent, frames_seen, writes_seen);
		$display("idle mixes sender/receiver: 30/83, 83/30 and none");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/qbtp_pkg.sv
design/qbtp_if.sv
design/quadrant_bar_test_pattern.sv
dv/tb_top.sv
